/* hdl/block_average_downscaler_defines.svh */
// assertion macros for the block average downscaler
`ifndef BLOCK_AVERAGE_DOWNSCALER_DEFINES_SVH
`define BLOCK_AVERAGE_DOWNSCALER_DEFINES_SVH
`ifndef SYNTHESIS
`define BAVG_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bavg check failed");
`define BAVG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bavg check failed");
`else
`define BAVG_ASSERT_SAME(label, ante, cons)
`define BAVG_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hdl/bavg_pkg.sv */
// shared constants and types for the block average downscaler
package bavg_pkg;

  localparam int MAX_WIDTH       = 4096;
  localparam int MAX_LOG2_FACTOR = 4;
  localparam int HEIGHT_LIMIT    = 4096;

  localparam int CFG_W   = 13;
  localparam int LG_W    = 3;
  localparam int PIX_W   = 8;
  localparam int SUM_W   = 16;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(HEIGHT_LIMIT);
  localparam int WID_W   = COL_W + 1;
  localparam int HGT_W   = ROW_W + 1;
  localparam int POS_W   = (WID_W > CFG_W) ? WID_W : CFG_W;
  localparam int SHIFT_W = $clog2(2 * MAX_LOG2_FACTOR + 1);
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [LG_W-1:0]  LOG2_RESET   = 3'd1;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_LOG2_FACTOR
  } reg_idx_t;

  typedef struct packed {
    logic [WID_W-1:0] width;
    logic [HGT_W-1:0] height;
    logic [LG_W-1:0]  lg;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [COL_W-1:0] blk;
    logic             col_first;
    logic             col_last;
    logic             row_first;
    logic             emit;
    logic             last;
  } q_item_t;

endpackage

/* hdl/block_average_downscaler.sv */
// top level of the power-of-two block average downscaler
// a block mean reaches the output register after its bottom-right pixel passes through the queue
// throughput: one pixel per cycle unless the queue is full, a line store write per block row segment
// a 4-entry queue separates pixel classification from accumulation
// reset: position counters zero, registers 640 x 480 and factor 2; line store not cleared
`include "block_average_downscaler_defines.svh"
module block_average_downscaler (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bavg_pkg::PIX_W-1:0]  in_pixel_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bavg_pkg::PIX_W-1:0]  out_mean_pixel,
  output logic                        out_last_of_frame,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bavg_pkg::ADDR_W-1:0] paddr,
  input  logic [bavg_pkg::DATA_W-1:0] pwdata,
  output logic [bavg_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  bavg_pkg::cfg_t             cfg;
  logic                       restart;
  logic                       q_push, q_pop, q_full, q_empty;
  bavg_pkg::q_item_t          push_item, pop_item;
  logic                       at_origin;
  logic                       ram_we, ram_re;
  logic [bavg_pkg::COL_W-1:0] ram_waddr, ram_raddr;
  logic [bavg_pkg::SUM_W-1:0] ram_wdata, ram_rdata;

  bavg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .restart (restart)
  );

  bavg_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .restart        (restart),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_value (in_pixel_value),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (push_item),
    .at_origin      (at_origin)
  );

  bavg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  bavg_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .lg                (cfg.lg),
    .q_empty           (q_empty),
    .q_item            (pop_item),
    .q_pop             (q_pop),
    .ram_we            (ram_we),
    .ram_waddr         (ram_waddr),
    .ram_wdata         (ram_wdata),
    .ram_re            (ram_re),
    .ram_raddr         (ram_raddr),
    .ram_rdata         (ram_rdata),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_mean_pixel    (out_mean_pixel),
    .out_last_of_frame (out_last_of_frame)
  );

  bavg_ram #(
    .WIDTH (bavg_pkg::SUM_W),
    .DEPTH (bavg_pkg::MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  `BAVG_ASSERT_NEXT(a_restart_origin, restart, at_origin)
  `BAVG_ASSERT_SAME(a_line_store_excl, ram_re, !ram_we)
  `BAVG_ASSERT_NEXT(a_queue_fill, q_push && !q_pop, !q_empty)

endmodule

/* hdl/bavg_ram.sv */
// generic single write port ram with registered read
module bavg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/bavg_regs.sv */
// apb configuration registers with clamping of frame geometry
module bavg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bavg_pkg::ADDR_W-1:0] paddr,
  input  logic [bavg_pkg::DATA_W-1:0] pwdata,
  output logic [bavg_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output bavg_pkg::cfg_t              cfg,
  output logic                        restart
);

  logic [bavg_pkg::CFG_W-1:0] image_width_r, image_width_nxt;
  logic [bavg_pkg::CFG_W-1:0] image_height_r, image_height_nxt;
  logic [bavg_pkg::LG_W-1:0]  log2_factor_r, log2_factor_nxt;
  logic                       wr_en;
  bavg_pkg::reg_idx_t         idx;
  logic [bavg_pkg::POS_W-1:0] w_x;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = bavg_pkg::reg_idx_t'(paddr[3:2]);

  always_comb begin
    image_width_nxt  = image_width_r;
    image_height_nxt = image_height_r;
    log2_factor_nxt  = log2_factor_r;
    restart          = 1'b0;
    prdata           = '0;
    case (idx)
      bavg_pkg::REG_IMAGE_WIDTH: begin
        prdata = bavg_pkg::DATA_W'(image_width_r);
        if (wr_en) begin
          image_width_nxt = pwdata[bavg_pkg::CFG_W-1:0];
          restart         = 1'b1;
        end
      end
      bavg_pkg::REG_IMAGE_HEIGHT: begin
        prdata = bavg_pkg::DATA_W'(image_height_r);
        if (wr_en) begin
          image_height_nxt = pwdata[bavg_pkg::CFG_W-1:0];
          restart          = 1'b1;
        end
      end
      bavg_pkg::REG_LOG2_FACTOR: begin
        prdata = bavg_pkg::DATA_W'(log2_factor_r);
        if (wr_en) begin
          log2_factor_nxt = pwdata[bavg_pkg::LG_W-1:0];
          restart         = 1'b1;
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= bavg_pkg::WIDTH_RESET;
      image_height_r <= bavg_pkg::HEIGHT_RESET;
      log2_factor_r  <= bavg_pkg::LOG2_RESET;
    end else begin
      image_width_r  <= image_width_nxt;
      image_height_r <= image_height_nxt;
      log2_factor_r  <= log2_factor_nxt;
    end
  end

  // clamp geometry to the supported range
  assign w_x = bavg_pkg::POS_W'(image_width_r);

  always_comb begin
    if (w_x == '0) begin
      cfg.width = bavg_pkg::WID_W'(1);
    end else if (w_x > bavg_pkg::POS_W'(bavg_pkg::MAX_WIDTH)) begin
      cfg.width = bavg_pkg::WID_W'(bavg_pkg::MAX_WIDTH);
    end else begin
      cfg.width = bavg_pkg::WID_W'(w_x);
    end

    if (image_height_r == '0) begin
      cfg.height = bavg_pkg::HGT_W'(1);
    end else if (image_height_r > bavg_pkg::CFG_W'(bavg_pkg::HEIGHT_LIMIT)) begin
      cfg.height = bavg_pkg::HGT_W'(bavg_pkg::HEIGHT_LIMIT);
    end else begin
      cfg.height = bavg_pkg::HGT_W'(image_height_r);
    end

    if (log2_factor_r > bavg_pkg::LG_W'(bavg_pkg::MAX_LOG2_FACTOR)) begin
      cfg.lg = bavg_pkg::LG_W'(bavg_pkg::MAX_LOG2_FACTOR);
    end else begin
      cfg.lg = log2_factor_r;
    end
  end

endmodule

/* hdl/bavg_front.sv */
// raster position tracking and classification of incoming pixels
module bavg_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bavg_pkg::cfg_t             cfg,
  input  logic                       restart,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [bavg_pkg::PIX_W-1:0] in_pixel_value,
  input  logic                       q_full,
  output logic                       q_push,
  output bavg_pkg::q_item_t          q_item,
  output logic                       at_origin
);

  logic [bavg_pkg::COL_W-1:0] col_r, col_nxt;
  logic [bavg_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [bavg_pkg::POS_W-1:0] col_x, row_x, w_x, h_x, mask_x;
  logic [bavg_pkg::POS_W-1:0] kept_cols, kept_rows, col_blk, num_blk;
  logic                       kept, row_last, accept, col_end, row_end;

  assign col_x  = bavg_pkg::POS_W'(col_r);
  assign row_x  = bavg_pkg::POS_W'(row_r);
  assign w_x    = bavg_pkg::POS_W'(cfg.width);
  assign h_x    = bavg_pkg::POS_W'(cfg.height);
  assign mask_x = ~({bavg_pkg::POS_W{1'b1}} << cfg.lg);

  assign kept_cols = w_x & ~mask_x;
  assign kept_rows = h_x & ~mask_x;
  assign kept      = (col_x < kept_cols) && (row_x < kept_rows);
  assign col_blk   = col_x >> cfg.lg;
  assign num_blk   = w_x >> cfg.lg;
  assign row_last  = (row_x & mask_x) == mask_x;

  always_comb begin
    q_item.pix       = in_pixel_value;
    q_item.blk       = bavg_pkg::COL_W'(col_blk);
    q_item.col_first = (col_x & mask_x) == '0;
    q_item.col_last  = (col_x & mask_x) == mask_x;
    q_item.row_first = (row_x & mask_x) == '0;
    q_item.emit      = q_item.col_last && row_last;
    q_item.last      = (row_x == kept_rows - 1'b1) && (col_blk == num_blk - 1'b1);
  end

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign q_push    = accept && kept;
  assign col_end   = (col_x + 1'b1) >= w_x;
  assign row_end   = (row_x + 1'b1) >= h_x;
  assign at_origin = (col_r == '0) && (row_r == '0);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : bavg_pkg::ROW_W'(row_x + 1'b1);
      end else begin
        col_nxt = bavg_pkg::COL_W'(col_x + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

/* hdl/bavg_queue.sv */
// small fifo between classification and accumulation
module bavg_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bavg_pkg::q_item_t push_item,
  input  logic              pop,
  output bavg_pkg::q_item_t pop_item,
  output logic              full,
  output logic              empty
);

  bavg_pkg::q_item_t         slot_r [bavg_pkg::QUEUE_DEPTH];
  logic [bavg_pkg::QP_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [bavg_pkg::QP_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [bavg_pkg::QP_W:0]   count_r, count_nxt;

  assign full     = count_r == (bavg_pkg::QP_W + 1)'(bavg_pkg::QUEUE_DEPTH);
  assign empty    = count_r == '0;
  assign pop_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* hdl/bavg_back.sv */
// block accumulation through the line store and output register
module bavg_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [bavg_pkg::LG_W-1:0]         lg,
  input  logic                              q_empty,
  input  bavg_pkg::q_item_t                 q_item,
  output logic                              q_pop,
  output logic                              ram_we,
  output logic [bavg_pkg::COL_W-1:0]        ram_waddr,
  output logic [bavg_pkg::SUM_W-1:0]        ram_wdata,
  output logic                              ram_re,
  output logic [bavg_pkg::COL_W-1:0]        ram_raddr,
  input  logic [bavg_pkg::SUM_W-1:0]        ram_rdata,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bavg_pkg::PIX_W-1:0]        out_mean_pixel,
  output logic                              out_last_of_frame
);

  logic [bavg_pkg::SUM_W-1:0]   seg_r, seg_nxt, seg_sum, total;
  logic                         out_valid_r, out_valid_nxt;
  logic [bavg_pkg::PIX_W-1:0]   mean_r, mean_nxt;
  logic                         last_r, last_nxt;
  logic [bavg_pkg::SHIFT_W-1:0] shamt;
  logic                         go;

  assign go    = !q_empty && (!out_valid_r || out_ready);
  assign q_pop = go;
  assign shamt = bavg_pkg::SHIFT_W'({lg, 1'b0});

  // horizontal run inside one block row, line store adds the rows above
  assign seg_sum = q_item.col_first ? bavg_pkg::SUM_W'(q_item.pix)
                                    : seg_r + bavg_pkg::SUM_W'(q_item.pix);
  assign total   = q_item.row_first ? seg_sum : ram_rdata + seg_sum;

  assign ram_re    = go && q_item.col_first && !q_item.row_first;
  assign ram_raddr = q_item.blk;
  assign ram_we    = go && q_item.col_last;
  assign ram_waddr = q_item.blk;
  assign ram_wdata = total;

  always_comb begin
    seg_nxt       = go ? seg_sum : seg_r;
    out_valid_nxt = out_valid_r;
    mean_nxt      = mean_r;
    last_nxt      = last_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (go && q_item.emit) begin
      out_valid_nxt = 1'b1;
      mean_nxt      = bavg_pkg::PIX_W'(total >> shamt);
      last_nxt      = q_item.last;
    end
  end

  always_ff @(posedge clk) begin
    seg_r  <= seg_nxt;
    mean_r <= mean_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_mean_pixel    = mean_r;
  assign out_last_of_frame = last_r;

endmodule

/* tb/block_average_downscaler_checker.sv */
// checker for the block average downscaler: tracks registers, predicts block means, compares
`timescale 1ns / 100ps
module block_average_downscaler_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [bavg_pkg::PIX_W-1:0]  in_pixel_value,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [bavg_pkg::PIX_W-1:0]  out_mean_pixel,
  input  logic                        out_last_of_frame,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bavg_pkg::ADDR_W-1:0] paddr,
  input  logic [bavg_pkg::DATA_W-1:0] pwdata,
  input  logic                        pready,
  output int                          error_count,
  output int                          pending_means
);

  typedef struct packed {
    logic [bavg_pkg::PIX_W-1:0] mean;
    logic                       last;
  } block_mean_t;

  logic [bavg_pkg::CFG_W-1:0] width_reg;
  logic [bavg_pkg::CFG_W-1:0] height_reg;
  logic [bavg_pkg::LG_W-1:0]  log2_reg;
  logic [bavg_pkg::SUM_W-1:0] column_sums [bavg_pkg::MAX_WIDTH];
  int unsigned                src_col;
  int unsigned                src_row;
  block_mean_t                expected_means [$];
  block_mean_t                oldest_mean;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic accumulate_pixel(input logic [bavg_pkg::PIX_W-1:0] pix);
    int unsigned w;
    int unsigned h;
    int unsigned lg;
    int unsigned mask;
    int unsigned out_cols;
    int unsigned out_rows;
    int unsigned blk;
    int unsigned sum;
    logic [bavg_pkg::SUM_W-1:0] sum16;
    block_mean_t result;
    w = (width_reg == 0) ? 1 :
        ((width_reg > bavg_pkg::MAX_WIDTH) ? bavg_pkg::MAX_WIDTH : width_reg);
    h = (height_reg == 0) ? 1 :
        ((height_reg > bavg_pkg::HEIGHT_LIMIT) ? bavg_pkg::HEIGHT_LIMIT : height_reg);
    lg = (log2_reg > bavg_pkg::MAX_LOG2_FACTOR) ? bavg_pkg::MAX_LOG2_FACTOR : log2_reg;
    mask = (1 << lg) - 1;
    out_cols = w >> lg;
    out_rows = h >> lg;
    if (src_col < (out_cols << lg) && src_row < (out_rows << lg)) begin
      blk = (src_col >> lg) % bavg_pkg::MAX_WIDTH;
      if ((src_row & mask) == 0 && (src_col & mask) == 0) begin
        sum = pix;
      end else begin
        sum = column_sums[blk] + pix;
      end
      sum16 = sum[bavg_pkg::SUM_W-1:0];
      column_sums[blk] = sum16;
      if ((src_row & mask) == mask && (src_col & mask) == mask) begin
        result.mean = bavg_pkg::PIX_W'(sum16 >> (2 * lg));
        result.last = (src_row == (out_rows << lg) - 1) && ((src_col >> lg) == out_cols - 1);
        expected_means.push_back(result);
      end
    end
    if (src_col + 1 >= w) begin
      src_col = 0;
      src_row = (src_row + 1 >= h) ? 0 : src_row + 1;
    end else begin
      src_col = src_col + 1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg = bavg_pkg::WIDTH_RESET;
      height_reg = bavg_pkg::HEIGHT_RESET;
      log2_reg = bavg_pkg::LOG2_RESET;
      src_col = 0;
      src_row = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_means.size() == 0) begin
          report_mismatch($sformatf("unexpected output transaction mean %0d last %0b",
                                    out_mean_pixel, out_last_of_frame));
        end else begin
          oldest_mean = expected_means.pop_front();
          if (out_mean_pixel !== oldest_mean.mean) begin
            report_mismatch($sformatf("mean_pixel got %0d want %0d",
                                      out_mean_pixel, oldest_mean.mean));
          end
          if (out_last_of_frame !== oldest_mean.last) begin
            report_mismatch($sformatf("last_of_frame got %0b want %0b",
                                      out_last_of_frame, oldest_mean.last));
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[bavg_pkg::ADDR_W-1:2])
          bavg_pkg::REG_IMAGE_WIDTH: begin
            width_reg = pwdata[bavg_pkg::CFG_W-1:0];
            src_col = 0;
            src_row = 0;
          end
          bavg_pkg::REG_IMAGE_HEIGHT: begin
            height_reg = pwdata[bavg_pkg::CFG_W-1:0];
            src_col = 0;
            src_row = 0;
          end
          bavg_pkg::REG_LOG2_FACTOR: begin
            log2_reg = pwdata[bavg_pkg::LG_W-1:0];
            src_col = 0;
            src_row = 0;
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        accumulate_pixel(in_pixel_value);
      end
    end
    pending_means = expected_means.size();
  end

endmodule

/* tb/block_average_downscaler_test.sv */
// testbench top for the block average downscaler: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module block_average_downscaler_test;

  localparam int RANDOM_PIXELS = 1650;
  localparam int DRAIN_CYCLES  = 16;
  localparam int CYCLE_LIMIT   = 400000;
  localparam logic [bavg_pkg::ADDR_W-1:0] SPARE_REG_ADDR = bavg_pkg::ADDR_W'(12);

  typedef enum {PIX_UNIFORM, PIX_MOSTLY_HIGH, PIX_MOSTLY_LOW, PIX_EXTREMES} pix_mix_t;
  typedef enum {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [bavg_pkg::PIX_W-1:0]  in_pixel_value = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [bavg_pkg::PIX_W-1:0]  out_mean_pixel;
  logic                        out_last_of_frame;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [bavg_pkg::ADDR_W-1:0] paddr = '0;
  logic [bavg_pkg::DATA_W-1:0] pwdata = '0;
  logic [bavg_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  int          error_count;
  int          pending_means;
  int          cycle_count = 0;
  int          stall_phase = 0;
  int          burst_left = 0;
  int          max_gap = 0;
  int          random_sent = 0;
  pix_mix_t    pixel_mix = PIX_UNIFORM;
  stall_mode_t stall_mode = STALL_LIGHT;

  block_average_downscaler dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pixel_value    (in_pixel_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_mean_pixel    (out_mean_pixel),
    .out_last_of_frame (out_last_of_frame),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  block_average_downscaler_checker mean_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pixel_value    (in_pixel_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_mean_pixel    (out_mean_pixel),
    .out_last_of_frame (out_last_of_frame),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .error_count       (error_count),
    .pending_means     (pending_means)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    case (stall_mode)
      STALL_NONE:     out_ready <= 1'b1;
      STALL_LIGHT:    out_ready <= ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: out_ready <= ((stall_phase % 5) < 3);
      default:        out_ready <= ($urandom_range(0, 9) < 4);
    endcase
  end

  function automatic logic [bavg_pkg::ADDR_W-1:0] reg_addr(input bavg_pkg::reg_idx_t idx);
    return bavg_pkg::ADDR_W'(idx) << 2;
  endfunction

  function automatic logic [bavg_pkg::DATA_W-1:0] with_noise(input int unsigned val,
                                                             input int bits);
    logic [bavg_pkg::DATA_W-1:0] keep;
    keep = (bavg_pkg::DATA_W'(1) << bits) - 1;
    if ($urandom_range(0, 1) != 0) begin
      return (bavg_pkg::DATA_W'($urandom) & ~keep) | (bavg_pkg::DATA_W'(val) & keep);
    end
    return bavg_pkg::DATA_W'(val) & keep;
  endfunction

  function automatic logic [bavg_pkg::PIX_W-1:0] pick_pixel();
    case (pixel_mix)
      PIX_MOSTLY_HIGH: return ($urandom_range(0, 7) != 0) ? '1 : bavg_pkg::PIX_W'($urandom);
      PIX_MOSTLY_LOW:  return ($urandom_range(0, 7) != 0) ? '0 : bavg_pkg::PIX_W'($urandom);
      PIX_EXTREMES: begin
        case ($urandom_range(0, 2))
          0:       return '0;
          1:       return '1;
          default: return bavg_pkg::PIX_W'($urandom);
        endcase
      end
      default: return bavg_pkg::PIX_W'($urandom);
    endcase
  endfunction

  task automatic write_word(input logic [bavg_pkg::ADDR_W-1:0] addr,
                            input logic [bavg_pkg::DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int unsigned w, input int unsigned h, input int unsigned lg);
    write_word(reg_addr(bavg_pkg::REG_IMAGE_WIDTH), with_noise(w, bavg_pkg::CFG_W));
    write_word(reg_addr(bavg_pkg::REG_IMAGE_HEIGHT), with_noise(h, bavg_pkg::CFG_W));
    write_word(reg_addr(bavg_pkg::REG_LOG2_FACTOR), with_noise(lg, bavg_pkg::LG_W));
  endtask

  // bursts of transactions separated by random gaps
  task automatic send_pixel(input logic [bavg_pkg::PIX_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_pixel_value <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_means != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase();
    int unsigned pick;
    int unsigned lg;
    int unsigned eff_lg;
    int unsigned edge_len;
    int unsigned w;
    int unsigned h;
    int unsigned w_eff;
    int unsigned h_eff;
    int unsigned frame;
    int unsigned n_items;
    int unsigned split;
    settle();
    pick = $urandom_range(0, 39);
    if (pick < 12) lg = 0;
    else if (pick < 22) lg = 1;
    else if (pick < 30) lg = 2;
    else if (pick < 35) lg = 3;
    else if (pick < 38) lg = 4;
    else lg = $urandom_range(5, 7);
    eff_lg = (lg > bavg_pkg::MAX_LOG2_FACTOR) ? bavg_pkg::MAX_LOG2_FACTOR : lg;
    edge_len = 1 << eff_lg;
    case (eff_lg)
      0: begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 8);
      end
      1: begin
        w = 2 * $urandom_range(1, 8) + $urandom_range(0, 1);
        h = 2 * $urandom_range(1, 4) + $urandom_range(0, 1);
      end
      2: begin
        w = 4 * $urandom_range(1, 5) + $urandom_range(0, 3);
        h = 4 * $urandom_range(1, 3) + $urandom_range(0, 3);
      end
      3: begin
        w = 8 * $urandom_range(1, 3) + $urandom_range(0, 7);
        h = 8 * $urandom_range(1, 2) + $urandom_range(0, 3);
      end
      default: begin
        w = 16 * $urandom_range(1, 2) + $urandom_range(0, 3);
        h = 16 + $urandom_range(0, 2);
      end
    endcase
    if ($urandom_range(0, 9) == 0) w = $urandom_range(1, edge_len);
    if ($urandom_range(0, 11) == 0) h = $urandom_range(1, edge_len);
    case ($urandom_range(0, 13))
      0: w = 0;
      1: w = bavg_pkg::MAX_WIDTH;
      2: w = (1 << bavg_pkg::CFG_W) - 1;
      3: h = 0;
      4: h = (1 << bavg_pkg::CFG_W) - 1;
      5: w = $urandom_range(0, (1 << bavg_pkg::CFG_W) - 1);
      6: h = bavg_pkg::HEIGHT_LIMIT;
      default: ;
    endcase
    w_eff = (w == 0) ? 1 : ((w > bavg_pkg::MAX_WIDTH) ? bavg_pkg::MAX_WIDTH : w);
    h_eff = (h == 0) ? 1 : ((h > bavg_pkg::HEIGHT_LIMIT) ? bavg_pkg::HEIGHT_LIMIT : h);
    frame = w_eff * h_eff;
    if (frame > 700) n_items = $urandom_range(8, 150);
    else if (frame > 200) n_items = frame + $urandom_range(0, 16);
    else n_items = frame * $urandom_range(1, 3) + $urandom_range(0, frame);
    if (n_items > RANDOM_PIXELS - random_sent) n_items = RANDOM_PIXELS - random_sent;
    split = ($urandom_range(0, 4) == 0) ? $urandom_range(1, n_items) : n_items;
    case ($urandom_range(0, 3))
      0:       max_gap = 0;
      1:       max_gap = 2;
      default: max_gap = 6;
    endcase
    stall_mode = stall_mode_t'($urandom_range(0, 3));
    pixel_mix = pix_mix_t'($urandom_range(0, 3));
    configure(w, h, lg);
    for (int i = 0; i < n_items; i++) begin
      if (i == split) begin
        settle();
        write_word(SPARE_REG_ADDR, $urandom);
      end
      send_pixel(pick_pixel());
      random_sent++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // a few pixels under the reset geometry, no block completes
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h80);

    // 2x2 frame with a 2x2 block: full scale, truncation, near zero
    settle();
    configure(2, 2, 1);
    repeat (4) send_pixel(8'hFF);
    send_pixel(8'hFE);
    repeat (3) send_pixel(8'hFF);
    send_pixel(8'h01);
    send_pixel(8'h00);
    send_pixel(8'h00);
    send_pixel(8'h02);

    // zero width and height act as one, factor one passes pixels through
    settle();
    configure(0, 0, 0);
    send_pixel(8'h00);
    send_pixel(8'hFF);

    // oversized factor saturates, frame smaller than one block emits nothing
    settle();
    configure(3, 3, 7);
    repeat (8) send_pixel(bavg_pkg::PIX_W'($urandom));

    while (random_sent < RANDOM_PIXELS) begin
      random_phase();
    end

    settle();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
